// ===== design/assert_macros.svh =====
// Assertion macros shared by the rate meter RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold in the same cycle as its trigger.
`define ASSERT_SAME(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("assertion failed in the same cycle as its trigger");

// The property must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("assertion failed in the cycle after its trigger");

`endif

// ===== design/swrm_pkg.sv =====
// Package for the sliding window rate meter: field widths, state codes and
// the command and status structs between controller and datapath. No dependencies.
package swrm_pkg;

    localparam int STAMP_W = 32;
    localparam int RATE_W  = 9;
    localparam int AVG_W   = 17;
    localparam int FRAC_W  = 8;
    localparam logic [STAMP_W-1:0] WINDOW_RESET = 32'd1000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_PUSH,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic latch;
        logic rd_en;
        logic drop;
        logic set_ovf;
        logic push;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic occ_zero;
        logic occ_full;
        logic age_old;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// ===== design/sliding_window_rate_meter.sv =====
// An accepted item is handled in order: entries older than the window are evicted from the ring
// one at a time, a full ring then drops its oldest entry and flags overflow, the item is pushed,
// and the divider takes W = clog2(D*D + 1) + 8 steps (W = 25 for D = 256), one quotient bit a
// step, before the result waits for the output. The next item is taken only once it is loaded.
// Asynchronous active-low reset empties the ring and sets the window to 1000000;
// the ring memories themselves are not cleared.
module sliding_window_rate_meter #(
    parameter int RING_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // event_time [31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // current_rate [8:0], average_rate [25:9], zeros
    output logic [0:0]  m_axis_tuser   // ring_overflow [0]
);
    import swrm_pkg::*;

    `include "assert_macros.svh"

    cmd_t              cmd;
    status_t           status;
    logic [RATE_W-1:0] current_rate;
    logic [AVG_W-1:0]  average_rate;
    logic              ring_overflow;

    assign cfg_ready = 1'b1;

    swrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swrm_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .event_time    (s_axis_tdata),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .current_rate  (current_rate),
        .average_rate  (average_rate),
        .ring_overflow (ring_overflow)
    );

    assign m_axis_tdata = {{(32 - RATE_W - AVG_W){1'b0}}, average_rate, current_rate};
    assign m_axis_tuser = ring_overflow;

    `ASSERT_NEXT(a_one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ASSERT_SAME(a_no_result_overwritten, cmd.out_load, status.out_free)
    `ASSERT_SAME(a_drop_needs_entry, cmd.drop, !status.occ_zero)
    `ASSERT_NEXT(a_push_fills_ring, cmd.push, !status.occ_zero)

endmodule

// ===== design/swrm_ctrl.sv =====
// Controller state machine of the rate meter: sequences eviction, push,
// division and result hand-off. Depends on swrm_pkg.
module swrm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  swrm_pkg::status_t status,
    output swrm_pkg::cmd_t    cmd
);
    import swrm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (status.occ_zero)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.age_old)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_READ;
                end
                else if (status.occ_full)
                begin
                    cmd.drop    = 1'b1;
                    cmd.set_ovf = 1'b1;
                    state_next  = ST_PUSH;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/swrm_datapath.sv =====
// Datapath of the rate meter: timestamp and count rings, pointers, running
// sum, restoring divider and output register. Depends on swrm_pkg.
module swrm_datapath #(
    parameter int RING_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swrm_pkg::cmd_t                cmd,
    output swrm_pkg::status_t             status,
    input  logic                          cfg_valid,
    input  logic [swrm_pkg::STAMP_W-1:0]  cfg_data,
    input  logic [swrm_pkg::STAMP_W-1:0]  event_time,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [swrm_pkg::RATE_W-1:0]   current_rate,
    output logic [swrm_pkg::AVG_W-1:0]    average_rate,
    output logic                          ring_overflow
);
    import swrm_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int OCC_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = $clog2(RING_DEPTH * RING_DEPTH + 1);
    localparam int DIV_W = SUM_W + FRAC_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [STAMP_W-1:0] stamp_mem [RING_DEPTH];
    logic [OCC_W-1:0]   count_mem [RING_DEPTH];

    logic [STAMP_W-1:0] window_reg;
    logic [PTR_W-1:0]   oldest_reg;
    logic [PTR_W-1:0]   newest_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               ovf_reg;
    logic               out_valid_reg;

    logic [STAMP_W-1:0] now_reg;
    logic [STAMP_W-1:0] stamp_rd_reg;
    logic [OCC_W-1:0]   count_rd_reg;
    logic [DIV_W-1:0]   dq_reg;
    logic [OCC_W-1:0]   rem_reg;
    logic [RATE_W-1:0]  rate_out_reg;
    logic [AVG_W-1:0]   avg_out_reg;
    logic               ovf_out_reg;

    logic [STAMP_W-1:0] age;
    logic [OCC_W-1:0]   occ_inc;
    logic [OCC_W:0]     trial;
    logic               trial_ge;
    logic [OCC_W-1:0]   rem_next;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign age      = now_reg - stamp_rd_reg;
    assign occ_inc  = occ_reg + OCC_W'(1);
    assign trial    = {rem_reg, dq_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, occ_reg};
    assign rem_next = trial_ge ? OCC_W'(trial - {1'b0, occ_reg}) : OCC_W'(trial);

    assign status.occ_zero = occ_reg == '0;
    assign status.occ_full = occ_reg == OCC_W'(RING_DEPTH);
    assign status.age_old  = age >= window_reg;
    assign status.div_last = cnt_reg == CNT_W'(DIV_W - 1);
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            occ_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                window_reg <= cfg_data;
            end
            if (cmd.latch)
            begin
                ovf_reg <= 1'b0;
            end
            else if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.drop)
            begin
                oldest_reg <= ring_next(oldest_reg);
                occ_reg    <= occ_reg - OCC_W'(1);
                sum_reg    <= sum_reg - SUM_W'(count_rd_reg);
            end
            else if (cmd.push)
            begin
                newest_reg <= ring_next(newest_reg);
                occ_reg    <= occ_inc;
                sum_reg    <= sum_reg + SUM_W'(occ_inc);
            end
            if (cmd.div_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            now_reg <= event_time;
        end
        if (cmd.rd_en)
        begin
            stamp_rd_reg <= stamp_mem[oldest_reg];
            count_rd_reg <= count_mem[oldest_reg];
        end
        if (cmd.push)
        begin
            stamp_mem[newest_reg] <= now_reg;
            count_mem[newest_reg] <= occ_inc;
        end
        if (cmd.div_start)
        begin
            dq_reg  <= {sum_reg, {FRAC_W{1'b0}}};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[DIV_W-2:0], trial_ge};
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            rate_out_reg <= RATE_W'(occ_reg);
            avg_out_reg  <= AVG_W'(dq_reg);
            ovf_out_reg  <= ovf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign current_rate  = rate_out_reg;
    assign average_rate  = avg_out_reg;
    assign ring_overflow = ovf_out_reg;

endmodule
